FILE: design/swm_pkg.sv
// swm_pkg: shared types and constants of the supply window monitor.
// Holds the configuration and result records, operation codes, the
// millivolt scaling constants and the stream bit layout. No dependencies.
package swm_pkg;

   // ADC code width and full scale
   localparam int CODE_W = 10;
   localparam longint unsigned FULL_SCALE = (64'd1 << CODE_W) - 64'd1;

   localparam int SETTLE_W = 8;
   localparam int COUNT_W  = 16;
   localparam int MV_W     = 16;
   localparam int STATE_W  = 2;

   // Register reset values
   localparam logic [CODE_W-1:0]   MIN_CODE_RST = CODE_W'(341);
   localparam logic [CODE_W-1:0]   MAX_CODE_RST = CODE_W'(853);
   localparam logic [SETTLE_W-1:0] SETTLE_RST   = SETTLE_W'(5);

   // CSR map: register index from paddr[3:2]
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   typedef enum logic [1:0] {
      REG_MIN_CODE = 2'd0,
      REG_MAX_CODE = 2'd1,
      REG_SETTLE   = 2'd2,
      REG_NONE     = 2'd3
   } reg_index_type;

   // Operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_ON      = 2'd1,
      OP_ON_CONT = 2'd2,
      OP_OFF     = 2'd3
   } op_type;

   // millivolts = round(code * 36000 / FS), done as (code*MULT + BIAS) >> SHIFT.
   // MULT and BIAS are rounded up; the total error stays below 2^SHIFT/FS,
   // which keeps the floor exact for every code.
   localparam longint unsigned MV_FULL   = 64'd36000;
   localparam int              MV_SHIFT  = 2 * CODE_W + 1;
   localparam longint unsigned MV_MULT   =
      ((MV_FULL << MV_SHIFT) + FULL_SCALE - 64'd1) / FULL_SCALE;
   localparam longint unsigned MV_BIAS   =
      (((FULL_SCALE / 64'd2) << MV_SHIFT) + FULL_SCALE - 64'd1) / FULL_SCALE;
   localparam int              MV_MULT_W = $clog2(MV_MULT + 64'd1);
   localparam int              MV_PROD_W = CODE_W + MV_MULT_W + 1;

   // Result stream layout in rsp_tdata, lowest bit first
   localparam int RSP_STATE_LSB = 0;
   localparam int RSP_GRANT_BIT = RSP_STATE_LSB + STATE_W;
   localparam int RSP_CONT_BIT  = RSP_GRANT_BIT + 1;
   localparam int RSP_MV_LSB    = RSP_CONT_BIT + 1;
   localparam int RSP_PEN_BIT   = RSP_MV_LSB + MV_W;
   localparam int RSP_PDIS_BIT  = RSP_PEN_BIT + 1;
   localparam int RSP_DC_LSB    = RSP_PDIS_BIT + 1;
   localparam int RSP_USED_W    = RSP_DC_LSB + COUNT_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;
   localparam int REQ_DATA_W    = ((CODE_W + 7) / 8) * 8;

   typedef struct packed {
      logic [CODE_W-1:0]   min_code;
      logic [CODE_W-1:0]   max_code;
      logic [SETTLE_W-1:0] settle_samples;
   } cfg_type;

   typedef struct packed {
      logic [STATE_W-1:0] supply_state;
      logic               request_granted;
      logic               was_continuous;
      logic               notify_valid;
      logic [MV_W-1:0]    notify_millivolts;
      logic               power_enable;
      logic               power_disable;
      logic [COUNT_W-1:0] disconnect_count;
   } rsp_type;

endpackage

FILE: design/swm_csr.sv
// swm_csr: APB-style register file holding the window limits and the
// settle length. Depends on swm_pkg.
module swm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output swm_pkg::cfg_type                  cfg
);

   swm_pkg::cfg_type       cfg_ff;
   swm_pkg::reg_index_type sel;
   logic                   wr_en;

   assign sel        = swm_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_code       <= swm_pkg::MIN_CODE_RST;
         cfg_ff.max_code       <= swm_pkg::MAX_CODE_RST;
         cfg_ff.settle_samples <= swm_pkg::SETTLE_RST;
      end else if (wr_en) begin
         unique case (sel)
            swm_pkg::REG_MIN_CODE:
               cfg_ff.min_code <= csr_pwdata[swm_pkg::CODE_W-1:0];
            swm_pkg::REG_MAX_CODE:
               cfg_ff.max_code <= csr_pwdata[swm_pkg::CODE_W-1:0];
            swm_pkg::REG_SETTLE:
               cfg_ff.settle_samples <= csr_pwdata[swm_pkg::SETTLE_W-1:0];
            swm_pkg::REG_NONE: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (sel)
         swm_pkg::REG_MIN_CODE:
            csr_prdata = swm_pkg::CSR_DATA_W'(cfg_ff.min_code);
         swm_pkg::REG_MAX_CODE:
            csr_prdata = swm_pkg::CSR_DATA_W'(cfg_ff.max_code);
         swm_pkg::REG_SETTLE:
            csr_prdata = swm_pkg::CSR_DATA_W'(cfg_ff.settle_samples);
         swm_pkg::REG_NONE:
            csr_prdata = '0;
      endcase
   end

endmodule

FILE: design/swm_step.sv
// swm_step: supply state machine, counters and flags, plus the result
// for the item in the input register. Depends on swm_pkg.
module swm_step (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_pkg::cfg_type              cfg,
   input  logic                          fire,
   input  swm_pkg::op_type               op,
   input  logic [swm_pkg::CODE_W-1:0]    code,
   output swm_pkg::rsp_type              rsp
);

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_SETTLE = 2'd1,
      MODE_ON     = 2'd2
   } mode_type;

   localparam int DIFF_W = swm_pkg::CODE_W + 4;

   mode_type                         mode_ff, mode_in;
   logic [swm_pkg::SETTLE_W-1:0]     settle_ff, settle_in, settle_inc;
   logic [swm_pkg::CODE_W-1:0]       last_ff, last_in;
   logic [swm_pkg::CODE_W-1:0]       reported_ff, reported_in;
   logic                             cont_ff, cont_in;
   logic [swm_pkg::COUNT_W-1:0]      drops_ff, drops_in;

   logic                             in_window;
   logic [swm_pkg::CODE_W-1:0]       diff;
   logic [DIFF_W-1:0]                diff10;
   logic                             big_change;
   logic                             notify;
   logic [swm_pkg::CODE_W-1:0]       notify_code;
   logic                             granted, was_cont, p_en, p_dis;
   logic [swm_pkg::MV_PROD_W-1:0]    mv_prod;

   // Window test and change test
   assign in_window  = (code >= cfg.min_code) && (code <= cfg.max_code);
   assign diff       = (reported_ff >= code) ? reported_ff - code : code - reported_ff;
   assign diff10     = (DIFF_W'(diff) << 3) + (DIFF_W'(diff) << 1);
   assign big_change = (cfg.max_code < cfg.min_code) ||
                       (diff10 > DIFF_W'(cfg.max_code - cfg.min_code));
   assign settle_inc = (settle_ff == '1) ? settle_ff : settle_ff + 1'b1;

   // Next state and per-item pulses
   always_comb begin
      mode_in     = mode_ff;
      settle_in   = settle_ff;
      last_in     = last_ff;
      reported_in = reported_ff;
      cont_in     = cont_ff;
      drops_in    = drops_ff;
      notify      = 1'b0;
      notify_code = code;
      granted     = 1'b0;
      was_cont    = 1'b0;
      p_en        = 1'b0;
      p_dis       = 1'b0;
      unique case (op)
         swm_pkg::OP_SAMPLE: begin
            last_in = code;
            case (mode_ff)
               MODE_OFF: begin
                  if (in_window) begin
                     mode_in   = MODE_SETTLE;
                     settle_in = '0;
                  end
               end
               MODE_SETTLE: begin
                  if (!in_window) begin
                     mode_in = MODE_OFF;
                  end else begin
                     settle_in = settle_inc;
                     if (settle_inc >= cfg.settle_samples) begin
                        mode_in = MODE_ON;
                        notify  = 1'b1;
                     end
                  end
               end
               MODE_ON: begin
                  if (!in_window) begin
                     // dropout
                     mode_in  = MODE_OFF;
                     p_dis    = 1'b1;
                     notify   = 1'b1;
                     cont_in  = 1'b0;
                     drops_in = (drops_ff == '1) ? drops_ff : drops_ff + 1'b1;
                  end else if (big_change) begin
                     reported_in = code;
                     notify      = 1'b1;
                  end
               end
               default: mode_in = MODE_OFF;
            endcase
         end
         swm_pkg::OP_ON, swm_pkg::OP_ON_CONT: begin
            if (mode_ff == MODE_ON) begin
               granted = 1'b1;
               p_en    = 1'b1;
               if (op == swm_pkg::OP_ON_CONT) begin
                  was_cont = cont_ff;
                  cont_in  = 1'b1;
               end
            end else begin
               notify      = 1'b1;
               notify_code = last_ff;
            end
         end
         swm_pkg::OP_OFF: p_dis = 1'b1;
      endcase
   end

   // Code to millivolts by scaled reciprocal
   assign mv_prod = swm_pkg::MV_PROD_W'(notify_code) *
                    swm_pkg::MV_PROD_W'(swm_pkg::MV_MULT) +
                    swm_pkg::MV_PROD_W'(swm_pkg::MV_BIAS);

   always_comb begin
      rsp.supply_state      = swm_pkg::STATE_W'(mode_in);
      rsp.request_granted   = granted;
      rsp.was_continuous    = was_cont;
      rsp.notify_valid      = notify;
      rsp.notify_millivolts = notify ? mv_prod[swm_pkg::MV_SHIFT +: swm_pkg::MV_W] : '0;
      rsp.power_enable      = p_en;
      rsp.power_disable     = p_dis;
      rsp.disconnect_count  = drops_in;
   end

   // State registers, advanced once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_OFF;
         settle_ff   <= '0;
         last_ff     <= '0;
         reported_ff <= '0;
         cont_ff     <= 1'b0;
         drops_ff    <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         settle_ff   <= settle_in;
         last_ff     <= last_in;
         reported_ff <= reported_in;
         cont_ff     <= cont_in;
         drops_ff    <= drops_in;
      end
   end

endmodule

FILE: design/supply_window_monitor_core.sv
// Supply window monitor.
// req channel: one transfer per item; req_tuser is the operation (sample,
// on request, on request with continuity, off), req_tdata the ADC code.
// Each accepted item yields exactly one rsp transfer with the supply state
// after the item, request grant and continuity answer, an optional voltage
// notification in millivolts (flagged by rsp_tuser), power enable/disable
// pulses and the saturating dropout count.
// An accepted item passes the input register, then the result register,
// where rsp_tvalid rises; a stalled result keeps it in the input
// register. Throughput: one item per cycle while rsp_tready stays high;
// the state machine closes its loop through one register per item.
// When rsp_tready is low the result register holds; the input register can
// still take one more item, then req_tready drops until the result moves.
// Reset clears both stages, the supply state (off), counters and flags and
// loads the register defaults (window 341..853, settle 5). Users must write
// registers over the csr port while no item is in flight; the block does not enforce it.
// Depends on swm_pkg, swm_csr and swm_step.
module supply_window_monitor_core (
   input  logic                               clock,
   input  logic                               reset,
   // item stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swm_pkg::REQ_DATA_W-1:0]     req_tdata,  // [9:0] adc_code
   input  logic [1:0]                         req_tuser,  // [1:0] operation
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] supply_state, [2] request_granted, [3] was_continuous,
   // [19:4] notify_millivolts, [20] power_enable, [21] power_disable,
   // [37:22] disconnect_count
   output logic [swm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser,  // [0] notify_valid
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   swm_pkg::cfg_type               cfg;
   swm_pkg::rsp_type               rsp_in, rsp_ff;
   logic                           in_valid_ff, out_valid_ff;
   swm_pkg::op_type                op_ff;
   logic [swm_pkg::CODE_W-1:0]     code_ff;
   logic                           advance, fire;

   swm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swm_step u_step (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (fire),
      .op    (op_ff),
      .code  (code_ff),
      .rsp   (rsp_in)
   );

   // Handshake: result register frees when empty or taken
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff   <= swm_pkg::op_type'(req_tuser);
         code_ff <= req_tdata[swm_pkg::CODE_W-1:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Pack the result transfer
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = rsp_ff.notify_valid;
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[swm_pkg::RSP_STATE_LSB +: swm_pkg::STATE_W] = rsp_ff.supply_state;
      rsp_tdata[swm_pkg::RSP_GRANT_BIT]                     = rsp_ff.request_granted;
      rsp_tdata[swm_pkg::RSP_CONT_BIT]                      = rsp_ff.was_continuous;
      rsp_tdata[swm_pkg::RSP_MV_LSB +: swm_pkg::MV_W]       = rsp_ff.notify_millivolts;
      rsp_tdata[swm_pkg::RSP_PEN_BIT]                       = rsp_ff.power_enable;
      rsp_tdata[swm_pkg::RSP_PDIS_BIT]                      = rsp_ff.power_disable;
      rsp_tdata[swm_pkg::RSP_DC_LSB +: swm_pkg::COUNT_W]    = rsp_ff.disconnect_count;
   end

endmodule

FILE: design/swm_checker.sv
// swm_checker: port-level assertions for the supply window monitor,
// bound to supply_window_monitor_core. Depends on swm_pkg.
module swm_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [swm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tuser
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Power enable only comes with a grant, never with a disable
   a_enable_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[swm_pkg::RSP_PEN_BIT] |->
         rsp_tdata[swm_pkg::RSP_GRANT_BIT] && !rsp_tdata[swm_pkg::RSP_PDIS_BIT])
      else $error("power enable without grant or with disable");

   // Millivolts are zero unless a notification is flagged
   a_mv_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[swm_pkg::RSP_MV_LSB +: swm_pkg::MV_W] == '0)
      else $error("millivolts reported without notification");

   // Continuity answer only on a granted request; state code in range
   a_cont_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[swm_pkg::RSP_CONT_BIT] ||
                      rsp_tdata[swm_pkg::RSP_GRANT_BIT]) &&
                     (rsp_tdata[swm_pkg::RSP_STATE_LSB +: swm_pkg::STATE_W] != 2'd3))
      else $error("continuity without grant or bad state code");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind supply_window_monitor_core swm_checker u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
